>>> rtl/core/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Types, register indexes and constants of the cascaded PID H-bridge drive.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam int GainFracBits = 8;
  localparam int DutyLimit    = 25088;
  localparam int DutyDeadband = 128;

  localparam logic [2:0] REG_CUR_GAINS = 3'd0;
  localparam logic [2:0] REG_CUR_DB    = 3'd1;
  localparam logic [2:0] REG_VEL_GAINS = 3'd2;
  localparam logic [2:0] REG_VEL_DB    = 3'd3;
  localparam logic [2:0] REG_CUR_LIMIT = 3'd4;
  localparam logic [2:0] REG_BRIDGE    = 3'd5;
  localparam logic [2:0] REG_PERIOD    = 3'd6;

  localparam logic [1:0] MODE_OPEN   = 2'd0;
  localparam logic [1:0] MODE_CUR    = 2'd1;
  localparam logic [1:0] MODE_VEL    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // multiplier operand select
  localparam logic [1:0] MUL_KP = 2'd0;
  localparam logic [1:0] MUL_KI = 2'd1;
  localparam logic [1:0] MUL_KD = 2'd2;
  localparam logic [1:0] MUL_PW = 2'd3;

  typedef struct packed {
    logic [1:0]         ctrl_mode;
    logic               running;
    logic               drive_enable;
    logic signed [15:0] target;
    logic signed [15:0] measured_current;
    logic signed [15:0] measured_velocity;
    logic               velocity_fresh;
  } cpd_in_t;

  typedef struct packed {
    logic signed [15:0] duty;
    logic [15:0]        high_left_compare;
    logic [15:0]        low_left_compare;
    logic [15:0]        high_right_compare;
    logic [15:0]        low_right_compare;
    logic               bridge_enable;
  } cpd_out_t;

  // shared multiplier command
  typedef struct packed {
    logic       en;
    logic [1:0] sel;
    logic       clr;
  } cpd_mul_t;

endpackage

>>> rtl/core/cpd_mac.sv
// ----------------------------------------------------------------------------
// cpd_mac
// Shared 17x33 signed multiply-accumulate: one product a cycle while en is set into a wide sum.
// ----------------------------------------------------------------------------
module cpd_mac import cpd_pkg::*; (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic [16:0]        coef,
  input  logic signed [32:0] opnd,
  output logic signed [51:0] acc
);
  logic signed [51:0] acc_r, acc_nxt;
  logic signed [50:0] prod;

  assign prod = $signed({1'b0, coef}) * opnd;

  always_comb begin
    acc_nxt = acc_r;
    if (clr) acc_nxt = '0;
    else if (en) acc_nxt = acc_r + 52'(prod);
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;
endmodule

>>> rtl/core/cascaded_pid_hbridge_drive.sv
// ----------------------------------------------------------------------------
// cascaded_pid_hbridge_drive
// Cascaded velocity/current PID with sign-magnitude H-bridge compare mapping.
// ----------------------------------------------------------------------------
// channel  dir  handshake       payload
// in       in   valid / stall   cpd_in_t
// out      out  valid / stall   cpd_out_t
// cfg      in   valid / ready   index 3b, data 48b
//
// per input beat: prep, then outside the deadband of a closed-loop mode Kp,
// Ki, Kd and finish (velocity then current for a fresh velocity-mode sample),
// then duty, scale, map and out. each PID term and the compare scaling pass
// one at a time through the one shared multiplier; no new beat is taken
// before the result is in the output register, where it waits while the next
// tick is computed; the map step holds while an older result stalls.
// reset is synchronous and resets loop state, registers and handshakes.
// ----------------------------------------------------------------------------
module cascaded_pid_hbridge_drive import cpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  cpd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output cpd_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_KP   = 4'd2;
  localparam logic [3:0] S_KI   = 4'd3;
  localparam logic [3:0] S_KD   = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_DUTY = 4'd6;
  localparam logic [3:0] S_SCL  = 4'd7;
  localparam logic [3:0] S_MAP  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [47:0] cur_gains_r, vel_gains_r;
  logic [14:0] cur_db_r, vel_db_r, cur_lim_r;
  logic bridge_r;
  logic [15:0] period_r;

  logic signed [31:0] cur_int_r, vel_int_r;
  logic signed [16:0] cur_last_r, vel_last_r;
  logic signed [15:0] held_r;
  logic [1:0] last_mode_r;
  logic last_run_r;

  cpd_in_t  item_r;
  logic vel_phase_r;   // PID in flight is the velocity loop
  logic signed [16:0] err_r;
  logic signed [31:0] acc_r;   // saturated integral of the running loop
  logic signed [16:0] raw_r;   // clamped PID result or open-loop target
  logic signed [15:0] duty_r;
  logic out_valid_r;
  cpd_out_t out_r;

  cpd_mul_t mul;
  logic [16:0] coef;
  logic signed [32:0] opnd;
  logic signed [51:0] mac_acc;

  cpd_mac u_mac (
    .clk(clk), .clr(mul.clr), .en(mul.en), .coef(coef), .opnd(opnd), .acc(mac_acc)
  );

  logic [47:0] gains;
  logic signed [16:0] last_e;
  logic signed [31:0] integ;
  assign gains  = vel_phase_r ? vel_gains_r : cur_gains_r;
  assign last_e = vel_phase_r ? vel_last_r : cur_last_r;
  assign integ  = vel_phase_r ? vel_int_r : cur_int_r;

  logic [15:0] duty_mag;
  assign duty_mag = duty_r[15] ? 16'(-duty_r) : 16'(duty_r);

  always_comb begin
    coef = '0;
    opnd = '0;
    unique case (mul.sel)
      MUL_KP: begin coef = {1'b0, gains[15:0]};  opnd = 33'(err_r); end
      MUL_KI: begin coef = {1'b0, gains[31:16]}; opnd = 33'(acc_r); end
      MUL_KD: begin coef = {1'b0, gains[47:32]}; opnd = 33'(err_r) - 33'(last_e); end
      MUL_PW: begin coef = {1'b0, period_r};     opnd = $signed({17'd0, duty_mag}); end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------ decode
  logic signed [16:0] t_abs, c_abs, v_abs;
  logic cur_act, vel_act, loop_clr;
  logic out_free;
  assign t_abs = item_r.target[15] ? -17'(item_r.target) : 17'(item_r.target);
  assign c_abs = item_r.measured_current[15] ? -17'(item_r.measured_current)
                                             : 17'(item_r.measured_current);
  assign v_abs = item_r.measured_velocity[15] ? -17'(item_r.measured_velocity)
                                              : 17'(item_r.measured_velocity);
  assign cur_act = (t_abs > $signed({2'b0, cur_db_r})) || (c_abs > $signed({2'b0, cur_db_r}));
  assign vel_act = (t_abs > $signed({2'b0, vel_db_r})) || (v_abs > $signed({2'b0, vel_db_r}));
  assign loop_clr = (in_data.ctrl_mode != last_mode_r) || (in_data.running && !last_run_r);
  // output register empty or emptied at this edge
  assign out_free = !out_valid_r || !out_stall;

  logic signed [32:0] int_sum;
  logic signed [31:0] int_sat;
  assign int_sum = 33'(integ) + 33'(err_r);
  assign int_sat = (int_sum > 33'sd2147483647) ? 32'sh7fffffff :
                   (int_sum < -33'sd2147483648) ? 32'sh80000000 : 32'(int_sum);

  // floor shift of the PID sum and symmetric clamp
  logic signed [43:0] pid_sh;
  logic signed [16:0] lim, pid_cl;
  assign pid_sh = 44'(mac_acc >>> GainFracBits);
  assign lim = vel_phase_r ?
      ((cur_lim_r > 15'(DutyLimit)) ? 17'sd25088 : $signed({2'b0, cur_lim_r})) :
      17'sd25088;
  assign pid_cl = (pid_sh > 44'(lim)) ? lim : (pid_sh < -44'(lim)) ? -lim : 17'(pid_sh);

  // m = floor(prod / 25600): prod = period*|duty| < 2^31, 25600 = 2^10 * 25
  logic [31:0] prod_u;
  logic [21:0] q_hi;
  logic [15:0] m_val;
  assign prod_u = 32'(mac_acc);
  assign q_hi  = prod_u[31:10];
  // divide by 25 via reciprocal 2^32/25 rounded up, exact for 22-bit inputs
  logic [54:0] recip;
  assign recip = 55'(q_hi) * 55'd171798692;
  assign m_val = 16'(recip >> 32);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    mul = '0;
    unique case (state_r)
      S_IDLE: if (in_valid && !in_stall) state_nxt = S_PREP;
      S_PREP: begin
        mul.clr = 1'b1;
        if (item_r.ctrl_mode == MODE_CUR && cur_act) state_nxt = S_KP;
        else if (item_r.ctrl_mode == MODE_VEL && vel_act) state_nxt = S_KP;
        else state_nxt = S_DUTY;
      end
      S_KP: begin mul.en = 1'b1; mul.sel = MUL_KP; state_nxt = S_KI; end
      S_KI: begin mul.en = 1'b1; mul.sel = MUL_KI; state_nxt = S_KD; end
      S_KD: begin mul.en = 1'b1; mul.sel = MUL_KD; state_nxt = S_FIN; end
      S_FIN: begin
        mul.clr = 1'b1;
        state_nxt = vel_phase_r ? S_KP : S_DUTY;
      end
      S_DUTY: begin mul.clr = 1'b1; state_nxt = S_SCL; end
      S_SCL: begin mul.en = 1'b1; mul.sel = MUL_PW; state_nxt = S_MAP; end
      S_MAP: if (out_free) state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_gains_r <= '0; vel_gains_r <= '0;
      cur_db_r <= '0; vel_db_r <= '0; cur_lim_r <= '0;
      bridge_r <= 1'b0; period_r <= 16'd6000;
      cur_int_r <= '0; vel_int_r <= '0; cur_last_r <= '0; vel_last_r <= '0;
      held_r <= '0; last_mode_r <= MODE_OPEN; last_run_r <= 1'b0;
      out_valid_r <= 1'b0;
      vel_phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CUR_GAINS: cur_gains_r <= cfg_data;
          REG_CUR_DB:    cur_db_r <= cfg_data[14:0];
          REG_VEL_GAINS: vel_gains_r <= cfg_data;
          REG_VEL_DB:    vel_db_r <= cfg_data[14:0];
          REG_CUR_LIMIT: cur_lim_r <= cfg_data[14:0];
          REG_BRIDGE:    bridge_r <= cfg_data[0];
          REG_PERIOD:    period_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          item_r <= in_data;
          if (loop_clr) begin
            cur_int_r <= '0; vel_int_r <= '0; cur_last_r <= '0; vel_last_r <= '0;
          end
          last_mode_r <= in_data.ctrl_mode;
          last_run_r <= in_data.running;
        end
        S_PREP: begin
          raw_r <= (item_r.ctrl_mode == MODE_OPEN) ? 17'(item_r.target) : '0;
          if (item_r.ctrl_mode == MODE_VEL && item_r.velocity_fresh) begin
            vel_phase_r <= 1'b1;
            err_r <= 17'(item_r.target) - 17'(item_r.measured_velocity);
          end else begin
            vel_phase_r <= 1'b0;
            err_r <= (item_r.ctrl_mode == MODE_VEL ?
                      17'(held_r) : 17'(item_r.target)) - 17'(item_r.measured_current);
          end
        end
        S_KP: begin
          acc_r <= int_sat;
          if (vel_phase_r) vel_int_r <= int_sat; else cur_int_r <= int_sat;
        end
        S_KD: begin
          if (vel_phase_r) vel_last_r <= err_r; else cur_last_r <= err_r;
        end
        S_FIN: begin
          if (vel_phase_r) begin
            held_r <= 16'(pid_cl);
            err_r <= pid_cl - 17'(item_r.measured_current);
            vel_phase_r <= 1'b0;
          end else begin
            raw_r <= pid_cl;
          end
        end
        S_DUTY: begin
          if (!item_r.running) duty_r <= '0;
          else if (raw_r > 17'sd25088) duty_r <= 16'sd25088;
          else if (raw_r < -17'sd25088) duty_r <= -16'sd25088;
          else duty_r <= 16'(raw_r);
        end
        S_MAP: if (out_free) begin
          out_r.duty <= duty_r;
          out_r.bridge_enable <= item_r.running & item_r.drive_enable;
          out_r.high_left_compare <= 16'd1;
          out_r.low_left_compare <= 16'd1;
          out_r.high_right_compare <= 16'd1;
          out_r.low_right_compare <= 16'd1;
          if (!bridge_r && duty_mag >= 16'(DutyDeadband)) begin
            if (!duty_r[15]) begin
              out_r.high_left_compare <= m_val;
              out_r.low_right_compare <= period_r - 16'd1;
            end else begin
              out_r.low_left_compare <= period_r - 16'd1;
              out_r.high_right_compare <= m_val;
            end
          end
        end
        S_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data))) else $error("out dropped");
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.duty <= 16'sd25088 && out_data.duty >= -16'sd25088))
    else $error("duty out of range");
endmodule
